FILE: hdl/smc_pkg.sv
// Shared types and constants for the shutter motor controller.
// No dependencies.
package smc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int DECIDE_W = 16;
    localparam int TRAVEL_W = 20;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W = 2;

    localparam logic [SAMPLE_W-1:0] SAMPLE_RST = 16'd100;
    localparam logic [DECIDE_W-1:0] DECIDE_RST = 16'd500;
    localparam logic [TRAVEL_W-1:0] TRAVEL_RST = 20'd30000;
    localparam logic [DECIDE_W-1:0] DECIDE_MAX = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRAVEL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACT_LOW = 2'd3;

    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_JOG_UP = 3'd1;
    localparam logic [2:0] MODE_JOG_DOWN = 3'd2;
    localparam logic [2:0] MODE_RUN_UP = 3'd3;
    localparam logic [2:0] MODE_RUN_DOWN = 3'd4;
    localparam logic [2:0] MODE_STOPPING = 3'd5;

    localparam logic [2:0] PC_NONE = 3'd0;
    localparam logic [2:0] PC_HOLD_UP = 3'd1;
    localparam logic [2:0] PC_HOLD_DOWN = 3'd2;
    localparam logic [2:0] PC_PRESS_UP = 3'd3;
    localparam logic [2:0] PC_PRESS_DOWN = 3'd4;

    localparam logic [1:0] POS_UNDEF = 2'd0;
    localparam logic [1:0] POS_OPEN = 2'd1;
    localparam logic [1:0] POS_CLOSED = 2'd2;

    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_OPEN = 2'd1;
    localparam logic [1:0] CMD_CLOSE = 2'd2;
    localparam logic [1:0] CMD_STOP = 2'd3;

    localparam logic [1:0] HOLD_MAX = 2'd3;
    localparam logic [1:0] HOLD_LONG = 2'd2;

    typedef struct packed {
        logic [2:0]          press_code;
        logic [1:0]          hold_up;
        logic [1:0]          hold_down;
        logic                prev_up;
        logic                prev_down;
        logic [DECIDE_W-1:0] decide_timer;
        logic [SAMPLE_W-1:0] sample_timer;
    } smc_btn_t;

endpackage

FILE: hdl/smc_sampler.sv
// Button sampler: sample/decide timers, hold counters and press code update.
// Depends on smc_pkg.
module smc_sampler (
    input  smc_pkg::smc_btn_t                cur,
    input  logic                             up,
    input  logic                             down,
    input  logic [smc_pkg::SAMPLE_W-1:0]     sample_interval,
    input  logic [smc_pkg::DECIDE_W-1:0]     decide_interval,
    output smc_pkg::smc_btn_t                nxt
);

    logic [1:0] hu;
    logic [1:0] hd;
    logic [2:0] pc;

    always_comb begin
        nxt = cur;
        hu = cur.hold_up;
        hd = cur.hold_down;
        pc = cur.press_code;
        if (cur.sample_timer >= sample_interval) begin
            nxt.sample_timer = '0;
            if (up && hu < smc_pkg::HOLD_MAX) begin
                hu = hu + 2'd1;
            end
            if (down && hd < smc_pkg::HOLD_MAX) begin
                hd = hd + 2'd1;
            end
            if (!up) begin
                if (cur.prev_up && hu < smc_pkg::HOLD_LONG) begin
                    pc = smc_pkg::PC_PRESS_UP;
                end else if (pc == smc_pkg::PC_PRESS_UP) begin
                    pc = smc_pkg::PC_NONE;
                end
                hu = '0;
            end
            if (!down) begin
                if (cur.prev_down && hd < smc_pkg::HOLD_LONG) begin
                    pc = smc_pkg::PC_PRESS_DOWN;
                end else if (pc == smc_pkg::PC_PRESS_DOWN) begin
                    pc = smc_pkg::PC_NONE;
                end
                hd = '0;
            end
            if (cur.decide_timer >= decide_interval) begin
                if (hu >= smc_pkg::HOLD_LONG) begin
                    pc = smc_pkg::PC_HOLD_UP;
                end else if (hd >= smc_pkg::HOLD_LONG) begin
                    pc = smc_pkg::PC_HOLD_DOWN;
                end else if (pc == smc_pkg::PC_HOLD_UP || pc == smc_pkg::PC_HOLD_DOWN) begin
                    pc = smc_pkg::PC_NONE;
                end
                nxt.decide_timer = '0;
            end else if (cur.decide_timer != smc_pkg::DECIDE_MAX) begin
                nxt.decide_timer = cur.decide_timer + 1'b1;
            end
            nxt.prev_up = up;
            nxt.prev_down = down;
        end else begin
            nxt.sample_timer = cur.sample_timer + 1'b1;
            if (cur.decide_timer != smc_pkg::DECIDE_MAX) begin
                nxt.decide_timer = cur.decide_timer + 1'b1;
            end
        end
        nxt.hold_up = hu;
        nxt.hold_down = hd;
        nxt.press_code = pc;
    end

endmodule

FILE: hdl/shutter_motor_controller_core.sv
// Shutter motor controller top level: config registers, motor state machine,
// result register. Depends on smc_pkg and smc_sampler.
//
//  channel  | ports                                   | beat
//  ---------+-----------------------------------------+-------------------------
//  s_       | s_button_up, s_button_down, s_cmd       | one tick, s_valid&s_ready
//  m_       | m_drive_up, m_drive_down, m_position,   | one result per tick,
//           | m_report                                | m_valid&m_ready
//  cfg_     | cfg_we, cfg_index, cfg_data             | write when cfg_we high
//
// One beat per cycle when s_ready; each result appears the cycle after its beat.
// All state updates in a single combinational pass into the state registers.
// Synchronous active-low reset clears state and loads register defaults.
// s_ready drops only while a result is held and m_ready is low.
module shutter_motor_controller_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_button_up,
    input  logic                             s_button_down,
    input  logic [1:0]                       s_cmd,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_drive_up,
    output logic                             m_drive_down,
    output logic [1:0]                       m_position,
    output logic                             m_report,
    input  logic                             cfg_we,
    input  logic [smc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [smc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [smc_pkg::SAMPLE_W-1:0] sample_interval_reg;
    logic [smc_pkg::DECIDE_W-1:0] decide_interval_reg;
    logic [smc_pkg::TRAVEL_W-1:0] travel_time_reg;
    logic                         act_low_reg;

    smc_pkg::smc_btn_t            btn_reg;
    smc_pkg::smc_btn_t            btn_next;
    logic [2:0]                   mode_reg;
    logic [2:0]                   mode_next;
    logic [1:0]                   pos_reg;
    logic [1:0]                   pos_next;
    logic [smc_pkg::TRAVEL_W-1:0] run_timer_reg;
    logic [smc_pkg::TRAVEL_W-1:0] run_timer_next;

    logic                         m_valid_reg;
    logic                         drive_up_reg;
    logic                         drive_down_reg;
    logic                         report_reg;
    logic                         drive_up_next;
    logic                         drive_down_next;
    logic                         report_next;

    logic                         up;
    logic                         down;
    logic                         accept;
    logic                         run_done;
    logic [2:0]                   code;

    assign up = s_button_up ^ act_low_reg;
    assign down = s_button_down ^ act_low_reg;
    assign s_ready = !m_valid_reg || m_ready;
    assign accept = s_valid && s_ready;

    smc_sampler u_sampler (
        .cur             (btn_reg),
        .up              (up),
        .down            (down),
        .sample_interval (sample_interval_reg),
        .decide_interval (decide_interval_reg),
        .nxt             (btn_next)
    );

    assign code = btn_next.press_code;
    assign run_done = run_timer_reg >= travel_time_reg;

    always_comb begin
        mode_next = mode_reg;
        pos_next = pos_reg;
        run_timer_next = run_timer_reg;
        drive_up_next = 1'b0;
        drive_down_next = 1'b0;
        report_next = 1'b0;
        unique case (mode_reg) inside
            smc_pkg::MODE_JOG_UP, smc_pkg::MODE_JOG_DOWN: begin
                drive_up_next = (mode_reg == smc_pkg::MODE_JOG_UP);
                drive_down_next = (mode_reg == smc_pkg::MODE_JOG_DOWN);
                pos_next = smc_pkg::POS_UNDEF;
                report_next = (mode_reg != code);
                mode_next = code;
                if (code == smc_pkg::MODE_RUN_UP || code == smc_pkg::MODE_RUN_DOWN) begin
                    run_timer_next = '0;
                end
            end
            smc_pkg::MODE_RUN_UP: begin
                drive_up_next = 1'b1;
                pos_next = smc_pkg::POS_UNDEF;
                if (code == smc_pkg::PC_HOLD_DOWN || code == smc_pkg::PC_PRESS_DOWN) begin
                    mode_next = smc_pkg::MODE_STOPPING;
                end
                if (run_done) begin
                    pos_next = smc_pkg::POS_OPEN;
                    mode_next = smc_pkg::MODE_STOPPING;
                end else begin
                    run_timer_next = run_timer_reg + 1'b1;
                end
            end
            smc_pkg::MODE_RUN_DOWN: begin
                drive_down_next = 1'b1;
                pos_next = smc_pkg::POS_UNDEF;
                if (code == smc_pkg::PC_HOLD_UP || code == smc_pkg::PC_PRESS_UP) begin
                    mode_next = smc_pkg::MODE_STOPPING;
                end
                if (run_done) begin
                    pos_next = smc_pkg::POS_CLOSED;
                    mode_next = smc_pkg::MODE_STOPPING;
                end else begin
                    run_timer_next = run_timer_reg + 1'b1;
                end
            end
            smc_pkg::MODE_STOPPING: begin
                report_next = 1'b1;
                mode_next = smc_pkg::MODE_IDLE;
            end
            default: begin
                mode_next = code;
                if (code == smc_pkg::MODE_RUN_UP || code == smc_pkg::MODE_RUN_DOWN) begin
                    run_timer_next = '0;
                end
            end
        endcase
        unique case (s_cmd)
            smc_pkg::CMD_OPEN: begin
                mode_next = smc_pkg::MODE_RUN_UP;
                run_timer_next = '0;
            end
            smc_pkg::CMD_CLOSE: begin
                mode_next = smc_pkg::MODE_RUN_DOWN;
                run_timer_next = '0;
            end
            smc_pkg::CMD_STOP: begin
                mode_next = smc_pkg::MODE_IDLE;
            end
            default: begin
            end
        endcase
    end

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_interval_reg <= smc_pkg::SAMPLE_RST;
            decide_interval_reg <= smc_pkg::DECIDE_RST;
            travel_time_reg <= smc_pkg::TRAVEL_RST;
            act_low_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                smc_pkg::REG_SAMPLE: sample_interval_reg <= cfg_data[smc_pkg::SAMPLE_W-1:0];
                smc_pkg::REG_DECIDE: decide_interval_reg <= cfg_data[smc_pkg::DECIDE_W-1:0];
                smc_pkg::REG_TRAVEL: travel_time_reg <= cfg_data[smc_pkg::TRAVEL_W-1:0];
                default: act_low_reg <= cfg_data[0];
            endcase
        end
    end

    // controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            btn_reg <= '0;
            mode_reg <= smc_pkg::MODE_IDLE;
            pos_reg <= smc_pkg::POS_UNDEF;
            run_timer_reg <= '0;
        end else if (accept) begin
            btn_reg <= btn_next;
            mode_reg <= mode_next;
            pos_reg <= pos_next;
            run_timer_reg <= run_timer_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            drive_up_reg <= drive_up_next;
            drive_down_reg <= drive_down_next;
            report_reg <= report_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_drive_up = drive_up_reg;
    assign m_drive_down = drive_down_reg;
    assign m_position = pos_reg;
    assign m_report = report_reg;

endmodule

FILE: sim/shutter_motor_controller_core_tb.sv
// Self-checking testbench for shutter_motor_controller_core: button press/hold
// and remote command ticks, checked against an in-bench motor predictor.
// Depends on smc_pkg and the shutter_motor_controller_core RTL.
`timescale 1ns / 100ps

module shutter_motor_controller_core_tb;

    typedef struct packed {
        logic       drive_up;
        logic       drive_down;
        logic [1:0] position;
        logic       report;
    } motor_out_t;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    logic                           s_button_up;
    logic                           s_button_down;
    logic [1:0]                     s_cmd;
    logic                           m_valid;
    logic                           m_ready;
    logic                           m_drive_up;
    logic                           m_drive_down;
    logic [1:0]                     m_position;
    logic                           m_report;
    logic                           cfg_we;
    logic [smc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [smc_pkg::CFG_DATA_W-1:0] cfg_data;

    // predictor copy of registers and state
    logic [smc_pkg::SAMPLE_W-1:0] cfg_sample = smc_pkg::SAMPLE_RST;
    logic [smc_pkg::DECIDE_W-1:0] cfg_decide = smc_pkg::DECIDE_RST;
    logic [smc_pkg::TRAVEL_W-1:0] cfg_travel = smc_pkg::TRAVEL_RST;
    logic                         cfg_act_low = 1'b0;

    logic [2:0]                   mode_q = smc_pkg::MODE_IDLE;
    logic [2:0]                   press_q = smc_pkg::PC_NONE;
    logic [1:0]                   pos_q = smc_pkg::POS_UNDEF;
    logic [smc_pkg::SAMPLE_W-1:0] smp_tmr = '0;
    logic [smc_pkg::DECIDE_W-1:0] dec_tmr = '0;
    logic [smc_pkg::TRAVEL_W-1:0] run_tmr = '0;
    logic [1:0]                   hold_up_q = '0;
    logic [1:0]                   hold_dn_q = '0;
    logic                         prev_up_q = 1'b0;
    logic                         prev_dn_q = 1'b0;

    motor_out_t motor_out_q[$];
    int mismatch_count = 0;
    int ticks_sent = 0;
    bit src_idle = 1'b1;
    bit sink_idle = 1'b1;
    int sink_hold = 0;

    shutter_motor_controller_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_button_up   (s_button_up),
        .s_button_down (s_button_down),
        .s_cmd         (s_cmd),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_drive_up    (m_drive_up),
        .m_drive_down  (m_drive_down),
        .m_position    (m_position),
        .m_report      (m_report),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #4 aclk = ~aclk;

    function automatic motor_out_t next_motor_outputs(input logic up_raw, input logic down_raw,
                                                      input logic [1:0] cmd);
        logic       up;
        logic       down;
        logic [2:0] code;
        motor_out_t res;
        up = up_raw ^ cfg_act_low;
        down = down_raw ^ cfg_act_low;
        res = '0;

        if (smp_tmr >= cfg_sample) begin
            if (up && hold_up_q < smc_pkg::HOLD_MAX) hold_up_q++;
            if (down && hold_dn_q < smc_pkg::HOLD_MAX) hold_dn_q++;
            if (!up) begin
                if (prev_up_q && hold_up_q < smc_pkg::HOLD_LONG) press_q = smc_pkg::PC_PRESS_UP;
                else if (press_q == smc_pkg::PC_PRESS_UP) press_q = smc_pkg::PC_NONE;
                hold_up_q = '0;
            end
            if (!down) begin
                if (prev_dn_q && hold_dn_q < smc_pkg::HOLD_LONG) press_q = smc_pkg::PC_PRESS_DOWN;
                else if (press_q == smc_pkg::PC_PRESS_DOWN) press_q = smc_pkg::PC_NONE;
                hold_dn_q = '0;
            end
            if (dec_tmr >= cfg_decide) begin
                if (hold_up_q >= smc_pkg::HOLD_LONG) press_q = smc_pkg::PC_HOLD_UP;
                else if (hold_dn_q >= smc_pkg::HOLD_LONG) press_q = smc_pkg::PC_HOLD_DOWN;
                else if (press_q == smc_pkg::PC_HOLD_UP || press_q == smc_pkg::PC_HOLD_DOWN)
                    press_q = smc_pkg::PC_NONE;
                dec_tmr = '0;
            end else if (dec_tmr < smc_pkg::DECIDE_MAX) begin
                dec_tmr++;
            end
            prev_up_q = up;
            prev_dn_q = down;
            smp_tmr = '0;
        end else begin
            smp_tmr++;
            if (dec_tmr < smc_pkg::DECIDE_MAX) dec_tmr++;
        end
        code = press_q;

        case (mode_q) inside
            smc_pkg::MODE_JOG_UP, smc_pkg::MODE_JOG_DOWN: begin
                res.drive_up = (mode_q == smc_pkg::MODE_JOG_UP);
                res.drive_down = !res.drive_up;
                pos_q = smc_pkg::POS_UNDEF;
                if (mode_q != code) res.report = 1'b1;
                mode_q = code;
                if (mode_q == smc_pkg::MODE_RUN_UP || mode_q == smc_pkg::MODE_RUN_DOWN)
                    run_tmr = '0;
            end
            smc_pkg::MODE_RUN_UP: begin
                res.drive_up = 1'b1;
                pos_q = smc_pkg::POS_UNDEF;
                if (code == smc_pkg::PC_HOLD_DOWN || code == smc_pkg::PC_PRESS_DOWN)
                    mode_q = smc_pkg::MODE_STOPPING;
                if (run_tmr >= cfg_travel) begin
                    pos_q = smc_pkg::POS_OPEN;
                    mode_q = smc_pkg::MODE_STOPPING;
                end else begin
                    run_tmr++;
                end
            end
            smc_pkg::MODE_RUN_DOWN: begin
                res.drive_down = 1'b1;
                pos_q = smc_pkg::POS_UNDEF;
                if (code == smc_pkg::PC_HOLD_UP || code == smc_pkg::PC_PRESS_UP)
                    mode_q = smc_pkg::MODE_STOPPING;
                if (run_tmr >= cfg_travel) begin
                    pos_q = smc_pkg::POS_CLOSED;
                    mode_q = smc_pkg::MODE_STOPPING;
                end else begin
                    run_tmr++;
                end
            end
            smc_pkg::MODE_STOPPING: begin
                res.report = 1'b1;
                mode_q = smc_pkg::MODE_IDLE;
            end
            default: begin
                mode_q = code;
                if (mode_q == smc_pkg::MODE_RUN_UP || mode_q == smc_pkg::MODE_RUN_DOWN)
                    run_tmr = '0;
            end
        endcase

        case (cmd)
            smc_pkg::CMD_OPEN: begin
                mode_q = smc_pkg::MODE_RUN_UP;
                run_tmr = '0;
            end
            smc_pkg::CMD_CLOSE: begin
                mode_q = smc_pkg::MODE_RUN_DOWN;
                run_tmr = '0;
            end
            smc_pkg::CMD_STOP: mode_q = smc_pkg::MODE_IDLE;
            default: ;
        endcase

        res.position = pos_q;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // tick beats feed the predictor, result beats are checked against it
    always @(posedge aclk) begin : check_results
        motor_out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (motor_out_q.size() == 0) begin
                    report_mismatch("result beat with no tick pending");
                end else begin
                    want = motor_out_q.pop_front();
                    if (m_drive_up !== want.drive_up)
                        report_mismatch($sformatf("drive_up got %b expected %b",
                                                  m_drive_up, want.drive_up));
                    if (m_drive_down !== want.drive_down)
                        report_mismatch($sformatf("drive_down got %b expected %b",
                                                  m_drive_down, want.drive_down));
                    if (m_position !== want.position)
                        report_mismatch($sformatf("position got %0d expected %0d",
                                                  m_position, want.position));
                    if (m_report !== want.report)
                        report_mismatch($sformatf("report got %b expected %b",
                                                  m_report, want.report));
                end
            end
            if (s_valid && s_ready)
                motor_out_q.push_back(next_motor_outputs(s_button_up, s_button_down, s_cmd));
        end
    end

    // result receiver: per-beat stall, plus an optional long hold-off
    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            stall = sink_hold + (sink_idle ? $urandom_range(0, 11) : 0);
            sink_hold = 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic send_tick(input logic up, input logic down, input logic [1:0] cmd);
        int gap;
        gap = src_idle ? $urandom_range(0, 11) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_button_up <= up;
        s_button_down <= down;
        s_cmd <= cmd;
        do @(posedge aclk); while (!s_ready);
        ticks_sent++;
    endtask

    // levels are as pressed; the pin polarity follows cfg_act_low
    task automatic drive_levels(input logic up, input logic down, input logic [1:0] cmd,
                                input int n);
        repeat (n) send_tick(up ^ cfg_act_low, down ^ cfg_act_low, cmd);
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (motor_out_q.size() == 0);
    endtask

    task automatic write_reg(input logic [smc_pkg::CFG_IDX_W-1:0] idx, input int value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[smc_pkg::CFG_DATA_W-1:0];
        @(posedge aclk);
        case (idx)
            smc_pkg::REG_SAMPLE: cfg_sample = value[smc_pkg::SAMPLE_W-1:0];
            smc_pkg::REG_DECIDE: cfg_decide = value[smc_pkg::DECIDE_W-1:0];
            smc_pkg::REG_TRAVEL: cfg_travel = value[smc_pkg::TRAVEL_W-1:0];
            smc_pkg::REG_ACT_LOW: cfg_act_low = value[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int sample, input int decide, input int travel,
                              input int act_low);
        settle();
        write_reg(smc_pkg::REG_SAMPLE, sample);
        write_reg(smc_pkg::REG_DECIDE, decide);
        write_reg(smc_pkg::REG_TRAVEL, travel);
        write_reg(smc_pkg::REG_ACT_LOW, act_low);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // mostly well-formed presses, holds and runs, some commands and raw noise
    task automatic gen_traffic(input int n_ticks);
        int start;
        int kind;
        int len;
        int btn;
        start = ticks_sent;
        while (ticks_sent - start < n_ticks) begin
            if ($urandom_range(0, 7) == 0) src_idle = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 7) == 0) sink_idle = 1'($urandom_range(0, 1));
            kind = $urandom_range(0, 9);
            btn = $urandom_range(0, 1);
            case (kind) inside
                0, 1, 2: begin
                    len = $urandom_range(1, 2 * (cfg_sample + 1));
                    drive_levels(btn == 0, btn == 1, smc_pkg::CMD_NONE, len);
                    drive_levels(1'b0, 1'b0, smc_pkg::CMD_NONE,
                                 $urandom_range(1, 3 * (cfg_sample + 1)));
                end
                3, 4: begin
                    len = (cfg_sample + 1) * $urandom_range(2, 5) + $urandom_range(0, cfg_decide);
                    drive_levels(btn == 0, btn == 1, smc_pkg::CMD_NONE, len);
                    drive_levels(1'b0, 1'b0, smc_pkg::CMD_NONE,
                                 $urandom_range(1, 2 * (cfg_sample + 1)));
                end
                5: drive_levels(1'b0, 1'b0, smc_pkg::CMD_NONE, $urandom_range(1, cfg_travel + 4));
                6: drive_levels(1'b0, 1'b0,
                                2'($urandom_range(smc_pkg::CMD_OPEN, smc_pkg::CMD_STOP)), 1);
                7: repeat ($urandom_range(1, 8))
                    send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              2'($urandom_range(0, 3)));
                8: drive_levels(1'b1, 1'b1, smc_pkg::CMD_NONE,
                                $urandom_range(1, 4 * (cfg_sample + 1)));
                default: drive_levels(btn == 0, btn == 1, 2'($urandom_range(0, 3)),
                                      $urandom_range(1, 3));
            endcase
        end
    endtask

    task automatic test_directed();
        set_config(1, 1, 6, 0);
        drive_levels(1'b0, 1'b0, smc_pkg::CMD_OPEN, 1);
        drive_levels(1'b0, 1'b0, smc_pkg::CMD_NONE, 9);   // full run up, stop, report
        drive_levels(1'b1, 1'b1, smc_pkg::CMD_CLOSE, 1);
        drive_levels(1'b0, 1'b0, smc_pkg::CMD_OPEN, 1);   // restart while running
        drive_levels(1'b0, 1'b0, smc_pkg::CMD_STOP, 1);
        drive_levels(1'b1, 1'b0, smc_pkg::CMD_NONE, 2);   // short press up starts a run
        drive_levels(1'b0, 1'b0, smc_pkg::CMD_NONE, 2);
        drive_levels(1'b0, 1'b1, smc_pkg::CMD_NONE, 2);   // opposite press stops it
        drive_levels(1'b0, 1'b0, smc_pkg::CMD_NONE, 2);
        drive_levels(1'b0, 1'b1, smc_pkg::CMD_NONE, 8);   // held down: jog
        drive_levels(1'b0, 1'b0, smc_pkg::CMD_NONE, 3);
    endtask

    task automatic test_extreme_config();
        set_config(65535, 65535, 1048575, 1);
        drive_levels(1'b0, 1'b0, smc_pkg::CMD_OPEN, 1);
        drive_levels(1'b1, 1'b1, smc_pkg::CMD_NONE, 2);
        drive_levels(1'b0, 1'b0, smc_pkg::CMD_STOP, 1);
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < 6; p++) begin
            if (p == 0)
                set_config(1, 1, 1, $urandom_range(0, 1));
            else
                set_config($urandom_range(1, 3), $urandom_range(1, 10), $urandom_range(1, 40),
                           $urandom_range(0, 1));
            src_idle = 1'b1;
            sink_idle = 1'b1;
            gen_traffic(140);
        end
    endtask

    task automatic test_backpressure();
        set_config(1, 2, 8, 0);
        src_idle = 1'b0;
        sink_idle = 1'b0;
        sink_hold = 64;
        gen_traffic(40);
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_button_up = 1'b0;
        s_button_down = 1'b0;
        s_cmd = smc_pkg::CMD_NONE;
        cfg_we = 1'b0;
        cfg_index = smc_pkg::REG_SAMPLE;
        cfg_data = '0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_extreme_config();
        test_random_phases();
        test_backpressure();

        settle();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
